>>> rtl/core/bccsoc_pkg.sv
// Shared types and constants of the coulomb-counting fuel gauge.
// Holds field widths, the voltage/percent table, register indexes and the
// request/response structs of the shared divider. Depends on nothing.
`default_nettype none

package bccsoc_pkg;

  localparam int CAP_W    = 16;
  localparam int DEAD_W   = 8;
  localparam int MV_W     = 15;
  localparam int IBAT_W   = 14;
  localparam int SOC_W    = 10;
  localparam int CHARGE_W = 28;

  // Each update stands for this many seconds of current flow.
  localparam int SECONDS_PER_UPDATE = 1;
  // Room for the current scaled by up to 60 seconds.
  localparam int STEP_W = IBAT_W + 7;

  localparam int FULL_VBUS_MV = 4500;
  localparam int FULL_VBAT_MV = 4150;
  localparam int MAS_PER_MAH  = 3600;
  localparam int SOC_SCALE    = 1000;

  // Shared multiplier and divider widths.
  localparam int MUL_A_W = CHARGE_W;
  localparam int MUL_B_W = 15;
  localparam int PROD_W  = 38;
  localparam int DIVD_W  = PROD_W;
  localparam int DIVS_W  = CHARGE_W;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);

  // Voltage/percent table, descending voltage.
  localparam int TBL_N = 10;
  localparam logic [MV_W-1:0] TBL_MV [TBL_N] = '{
    15'd4200, 15'd4100, 15'd4000, 15'd3900, 15'd3800,
    15'd3700, 15'd3600, 15'd3500, 15'd3300, 15'd3000
  };
  localparam logic [6:0] TBL_PCT [TBL_N] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd40, 7'd20, 7'd10, 7'd5, 7'd0
  };

  // Configuration register indexes.
  localparam logic [0:0] REG_CAPACITY = 1'd0;
  localparam logic [0:0] REG_DEADBAND = 1'd1;

  // Request kinds.
  localparam logic REQ_INIT   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/battery_coulomb_counter_soc_unit.sv
// Top level of the coulomb-counting battery fuel gauge: stream ports,
// configuration registers, sequencer, shared multiplier and the divider.
// Depends on bccsoc_pkg and bccsoc_div.
//
// Usage: each request on the slave stream is either an init (tuser = 0),
// which seeds the stored charge from the battery voltage through the table
// or from half of capacity, or a one-second update (tuser = 1), which
// filters the current and integrates it into the charge. Every request gives
// exactly one result on the master stream: state of charge in tenths of a
// percent, the charge in mA*s, the filtered current and the full flag.
// Requests are handled one at a time. A result whose percentage needs no
// division comes soonest; otherwise it waits on the 38-step shared divider,
// once for the percentage and once more for the table interpolation of an
// init from a voltage between table points. s_axis_tready is high only
// while the sequencer is idle, so a new request is accepted only after the
// previous one has left the sequencer.
// The result waits in an output register, so a new request is accepted
// while the receiver stalls; its own result then waits until that register
// is free. Reset clears the charge to 0, capacity to 210 mAh and deadband to
// 8 mA. The configuration channel is always ready and should be written only
// while no request is in flight.
`default_nettype none

module battery_coulomb_counter_soc_unit (
  input  logic        clk,
  input  logic        rst,
  // Requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] read_ok, [15:1] vbat_mv, [30:16] vbus_mv, [44:31] ibat_ma,
  // [45] not_charging, [47:46] zero
  input  logic [47:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] soc_tenths, [37:10] charge_mas, [51:38] ibat_filtered_ma,
  // [52] full_detected, [55:53] zero
  output logic [55:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bccsoc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FULL, ST_BRANCH, ST_SEEDMUL, ST_SEEDDIV, ST_SEEDWAIT,
    ST_SOCMUL, ST_SOCDIV, ST_SOCWAIT, ST_DONE
  } state_t;

  state_t state;

  // Configuration.
  logic [CAP_W-1:0]  capacity;
  logic [DEAD_W-1:0] deadband;

  // Latched request.
  logic                     req_type;
  logic                     read_ok;
  logic [MV_W-1:0]          vbat;
  logic [MV_W-1:0]          vbus;
  logic signed [IBAT_W-1:0] ibat;
  logic                     not_charging;

  // Working registers.
  logic [CHARGE_W-1:0]      charge;
  logic [CHARGE_W-1:0]      full;
  logic [PROD_W-1:0]        prod;
  logic [21:0]              cap36;
  logic [14:0]              num;
  logic [8:0]               span;
  logic                     v_high;
  logic                     v_low;
  logic [SOC_W-1:0]         soc;
  logic signed [IBAT_W-1:0] filt;
  logic                     full_flag;

  // Output register.
  logic [SOC_W-1:0]         out_soc;
  logic [CHARGE_W-1:0]      out_charge;
  logic signed [IBAT_W-1:0] out_filt;
  logic                     out_full;

  logic s_fire;
  logic m_fire;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  // Shared multiplier, operands chosen by the sequencer step.
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] mul_p;

  always_comb begin
    unique case (state)
      ST_FULL: begin
        mul_a = MUL_A_W'(capacity);
        mul_b = MUL_B_W'(MAS_PER_MAH);
      end
      ST_SEEDMUL: begin
        mul_a = MUL_A_W'(cap36);
        mul_b = num;
      end
      default: begin
        mul_a = charge;
        mul_b = MUL_B_W'(SOC_SCALE);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Table segment holding the battery voltage. The lowest index whose lower
  // point is at or below the voltage wins.
  logic [8:0]      seg_span;
  logic [14:0]     seg_base;
  logic [6:0]      seg_dp;
  logic [MV_W-1:0] seg_v0;
  logic [8:0]      vdiff;
  logic [15:0]     vprod;
  logic [14:0]     seg_num;

  always_comb begin
    seg_span = '0;
    seg_base = '0;
    seg_dp   = '0;
    seg_v0   = '0;
    for (int i = TBL_N - 2; i >= 0; i--) begin
      if (vbat >= TBL_MV[i+1]) begin
        seg_span = 9'(TBL_MV[i] - TBL_MV[i+1]);
        seg_base = 15'(TBL_PCT[i+1] * (TBL_MV[i] - TBL_MV[i+1]));
        seg_dp   = TBL_PCT[i] - TBL_PCT[i+1];
        seg_v0   = TBL_MV[i+1];
      end
    end
  end
  assign vdiff   = 9'(vbat - seg_v0);
  assign vprod   = 16'(vdiff) * 16'(seg_dp);
  assign seg_num = seg_base + vprod[14:0];

  // Update path: deadband, full-charge check and saturating integration.
  logic signed [IBAT_W:0]   cur_ext;
  logic [IBAT_W:0]          mag;
  logic signed [IBAT_W-1:0] filt_w;
  logic signed [STEP_W-1:0] step_mas;
  logic signed [29:0]       sum;
  logic [CHARGE_W-1:0]      full_w;
  logic [CHARGE_W-1:0]      upd_charge;
  logic                     full_cond;

  assign full_w    = prod[CHARGE_W-1:0];
  assign cur_ext   = (IBAT_W+1)'(ibat);
  assign mag       = cur_ext[IBAT_W] ? (IBAT_W+1)'(-cur_ext) : cur_ext;
  assign filt_w    = (mag < (IBAT_W+1)'(deadband)) ? '0 : ibat;
  assign step_mas  = STEP_W'(filt_w) * STEP_W'(SECONDS_PER_UPDATE);
  assign sum       = $signed({2'b00, charge}) + 30'(step_mas);
  assign full_cond = (vbus > MV_W'(FULL_VBUS_MV)) && not_charging &&
                     (vbat > MV_W'(FULL_VBAT_MV));

  always_comb begin
    if (full_cond) begin
      upd_charge = full_w;
    end else if (sum < 0) begin
      upd_charge = '0;
    end else if (sum > $signed({2'b00, full_w})) begin
      upd_charge = full_w;
    end else begin
      upd_charge = sum[CHARGE_W-1:0];
    end
  end

  // Shared divider.
  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  assign div_cmd.start    = (state == ST_SEEDDIV) || (state == ST_SOCDIV);
  assign div_cmd.dividend = prod;
  assign div_cmd.divisor  = (state == ST_SEEDDIV) ? DIVS_W'(span) : full;

  bccsoc_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity      <= CAP_W'(210);
      deadband      <= DEAD_W'(8);
      charge        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CAPACITY: capacity <= cfg_data;
          REG_DEADBAND: deadband <= cfg_data[DEAD_W-1:0];
        endcase
      end

      // A new result refills the output register in the cycle it drains.
      if ((state == ST_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_fire) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            req_type     <= s_axis_tuser;
            read_ok      <= s_axis_tdata[0];
            vbat         <= s_axis_tdata[15:1];
            vbus         <= s_axis_tdata[30:16];
            ibat         <= s_axis_tdata[44:31];
            not_charging <= s_axis_tdata[45];
            state        <= ST_FULL;
          end
        end
        ST_FULL: begin
          prod   <= PROD_W'(mul_p);
          cap36  <= {1'b0, capacity, 5'b0} + {4'b0, capacity, 2'b0};
          num    <= seg_num;
          span   <= seg_span;
          v_high <= (vbat >= TBL_MV[0]);
          v_low  <= (vbat <= TBL_MV[TBL_N-1]);
          state  <= ST_BRANCH;
        end
        ST_BRANCH: begin
          full <= full_w;
          if (req_type == REQ_INIT) begin
            filt      <= '0;
            full_flag <= 1'b0;
            if (!read_ok) begin
              // Full charge is always even, so the shift is the exact half.
              charge <= {1'b0, full_w[CHARGE_W-1:1]};
              state  <= ST_SOCMUL;
            end else if (v_high) begin
              charge <= full_w;
              state  <= ST_SOCMUL;
            end else if (v_low) begin
              charge <= '0;
              state  <= ST_SOCMUL;
            end else begin
              state <= ST_SEEDMUL;
            end
          end else begin
            charge    <= upd_charge;
            filt      <= full_cond ? '0 : filt_w;
            full_flag <= full_cond;
            state     <= ST_SOCMUL;
          end
        end
        ST_SEEDMUL: begin
          prod  <= PROD_W'(mul_p);
          state <= ST_SEEDDIV;
        end
        ST_SEEDDIV: begin
          state <= ST_SEEDWAIT;
        end
        ST_SEEDWAIT: begin
          if (div_rsp.done) begin
            charge <= div_rsp.quotient[CHARGE_W-1:0];
            state  <= ST_SOCMUL;
          end
        end
        ST_SOCMUL: begin
          // A charge at or above full capacity reads as 100 percent.
          if (full == '0) begin
            soc   <= '0;
            state <= ST_DONE;
          end else if (charge >= full) begin
            soc   <= SOC_W'(SOC_SCALE);
            state <= ST_DONE;
          end else begin
            prod  <= PROD_W'(mul_p);
            state <= ST_SOCDIV;
          end
        end
        ST_SOCDIV: begin
          state <= ST_SOCWAIT;
        end
        ST_SOCWAIT: begin
          if (div_rsp.done) begin
            soc   <= div_rsp.quotient[SOC_W-1:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_soc       <= soc;
            out_charge    <= charge;
            out_filt      <= filt;
            out_full      <= full_flag;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {3'b000, out_full, out_filt, out_charge, out_soc};

  // The divider is never left running while a new request can come in.
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy)
    else $error("divider busy while ready for a request");

  // A result never reports more than 100 percent.
  a_soc_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9:0] <= 10'd1000))
    else $error("soc_tenths above 1000");

  // A forced full charge always reports zero filtered current.
  a_full_filt: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[52]) |-> (m_axis_tdata[51:38] == '0))
    else $error("full flag with nonzero filtered current");

  // A divide result lands only in a state that is waiting for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> ((state == ST_SEEDWAIT) || (state == ST_SOCWAIT)))
    else $error("divider finished outside a wait step");

endmodule

`default_nettype wire

>>> rtl/core/bccsoc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the gauge.
// Depends on bccsoc_pkg for widths and the request/response structs.
`default_nettype none

module bccsoc_div (
  input  logic                 clk,
  input  logic                 rst,
  input  bccsoc_pkg::div_cmd_t cmd,
  output bccsoc_pkg::div_rsp_t rsp
);
  import bccsoc_pkg::*;

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] divisor;
  logic [DIVD_W-1:0] dq;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DIVS_W:0]   shifted;
  logic [DIVS_W+1:0] diff;
  logic              borrow;

  assign shifted = {rem, dq[DIVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign borrow  = diff[DIVS_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      dq      <= cmd.dividend;
      divisor <= cmd.divisor;
      rem     <= '0;
      cnt     <= DCNT_W'(DIVD_W);
      busy    <= 1'b1;
    end else if (busy) begin
      rem  <= borrow ? shifted[DIVS_W-1:0] : diff[DIVS_W-1:0];
      dq   <= {dq[DIVD_W-2:0], ~borrow};
      cnt  <= cnt - 1'b1;
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The done pulse follows the last quotient step.
  always_ff @(posedge clk) begin
    done <= !rst && !cmd.start && busy && (cnt == DCNT_W'(1));
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

`default_nettype wire
